FILE: hw/rtl/oale_pkg.sv
// oale_pkg: item types, command and status structs, and action and status codes
// for the ordered array list engine. No dependencies.

package oale_pkg;

	localparam int POS_W  = 6;
	localparam int DATA_W = 32;

	// actions
	localparam logic [2:0] ACT_INSERT = 3'd0;
	localparam logic [2:0] ACT_DELETE = 3'd1;
	localparam logic [2:0] ACT_UPDATE = 3'd2;
	localparam logic [2:0] ACT_SEARCH = 3'd3;
	localparam logic [2:0] ACT_DUMP   = 3'd4;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_BADPOS   = 3'd2;
	localparam logic [2:0] ST_FOUND    = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;
	localparam logic [2:0] ST_ELEMENT  = 3'd5;
	localparam logic [2:0] ST_EMPTY    = 3'd6;

	typedef struct packed {
		logic [2:0]              action;
		logic [POS_W-1:0]        position;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [2:0]              status;
		logic [POS_W-1:0]        index;
		logic signed [DATA_W-1:0] data;
		logic [POS_W-1:0]        length;
		logic                    last;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic       take;
		logic       rd_en;
		logic       wr_en;
		logic       mv;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       out_load;
		logic       out_use_data;
		logic       out_last;
		logic [2:0] out_status;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0]       action;
		logic [POS_W-1:0] position;
		logic             full;
		logic             ins_ok;
		logic             pos_ok;
		logic             empty;
		logic             match;
		logic             out_free;
	} dp_sts_t;

endpackage

FILE: hw/rtl/oale_dp.sv
// oale_dp: datapath of the ordered array list engine: item register, entry memory,
// entry count, shift move stage and result register. Uses oale_pkg.

module oale_dp #(
	parameter int DEPTH = 32,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  oale_pkg::req_t      req,
	input  oale_pkg::ctl_cmd_t  cmd,
	input  logic [AW-1:0]       rd_addr,
	input  logic [AW-1:0]       wr_addr,
	input  logic [AW-1:0]       out_index,
	output oale_pkg::dp_sts_t   sts,
	output logic [CW-1:0]       count,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output oale_pkg::rsp_t      rsp
);
	import oale_pkg::*;

	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

	req_t                    item_q;
	logic [CW-1:0]           count_q;
	logic signed [DATA_W-1:0] mem_q [DEPTH];
	logic signed [DATA_W-1:0] rd_data_q;
	logic                    mv_s1;
	logic [AW-1:0]           mv_addr_s1;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic signed [DATA_W-1:0] mem_wdata;
	logic                    out_free;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	// a move reads one entry and writes it one slot over in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s1 <= 1'b0;
		end else begin
			mv_s1 <= cmd.mv;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mv) begin
			mv_addr_s1 <= wr_addr;
		end
	end

	assign mem_we    = mv_s1 | cmd.wr_en;
	assign mem_waddr = mv_s1 ? mv_addr_s1 : wr_addr;
	assign mem_wdata = mv_s1 ? rd_data_q : item_q.value;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.status <= cmd.out_status;
			rsp_q.index  <= POS_W'(out_index);
			rsp_q.data   <= cmd.out_use_data ? rd_data_q : '0;
			rsp_q.length <= POS_W'(count_q);
			rsp_q.last   <= cmd.out_last;
		end
	end

	always_comb begin
		sts.action   = item_q.action;
		sts.position = item_q.position;
		sts.full     = (XW'(count_q) == XW'(DEPTH));
		sts.ins_ok   = (XW'(item_q.position) <= XW'(count_q));
		sts.pos_ok   = (XW'(item_q.position) < XW'(count_q));
		sts.empty    = (count_q == '0);
		sts.match    = (rd_data_q == item_q.value);
		sts.out_free = out_free;
	end

	assign count     = count_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(count_q) <= XW'(DEPTH))
		else $error("entry count above depth");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(mv_s1 && cmd.wr_en))
		else $error("move write collides with direct write");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("result register overwritten while held");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |=> count_q == $past(count_q) + CW'(1))
		else $error("count did not advance on insert");
`endif

endmodule

FILE: hw/rtl/oale_ctrl.sv
// oale_ctrl: controller state machine of the ordered array list engine; walks the
// entry memory for shifts, search and dump. Uses oale_pkg.

module oale_ctrl #(
	parameter int DEPTH = 32,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  oale_pkg::dp_sts_t   sts,
	input  logic [CW-1:0]       count,
	output oale_pkg::ctl_cmd_t  cmd,
	output logic [AW-1:0]       rd_addr,
	output logic [AW-1:0]       wr_addr,
	output logic [AW-1:0]       out_index
);
	import oale_pkg::*;

	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_SHUP   = 3'd2;
	localparam logic [2:0] S_INSW   = 3'd3;
	localparam logic [2:0] S_SHDN   = 3'd4;
	localparam logic [2:0] S_SCAN   = 3'd5;
	localparam logic [2:0] S_SFIN   = 3'd6;
	localparam logic [2:0] S_REPLY  = 3'd7;

	logic [2:0]    state_q, state_d;
	logic [AW-1:0] i_q, i_d;
	logic [2:0]    st_q, st_d;
	logic          pend_q, pend_d;
	logic [AW-1:0] pend_idx_q, pend_idx_d;
	logic          last_el;
	logic          is_search;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q        <= i_d;
		st_q       <= st_d;
		pend_idx_q <= pend_idx_d;
	end

	assign last_el   = (XW'(i_q) + XW'(1)) == XW'(count);
	assign is_search = (sts.action == ACT_SEARCH);
	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		i_d        = i_q;
		st_d       = st_q;
		pend_d     = pend_q;
		pend_idx_d = pend_idx_q;
		cmd        = '0;
		rd_addr    = '0;
		wr_addr    = '0;
		out_index  = '0;

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_REPLY;
				unique case (sts.action) inside
					ACT_INSERT: begin
						if (sts.full) begin
							st_d = ST_FULL;
						end else if (!sts.ins_ok) begin
							st_d = ST_BADPOS;
						end else begin
							i_d     = AW'(count);
							state_d = S_SHUP;
						end
					end
					ACT_DELETE: begin
						if (!sts.pos_ok) begin
							st_d = ST_BADPOS;
						end else begin
							i_d     = AW'(sts.position);
							state_d = S_SHDN;
						end
					end
					ACT_UPDATE: begin
						if (!sts.pos_ok) begin
							st_d = ST_BADPOS;
						end else begin
							cmd.wr_en = 1'b1;
							wr_addr   = AW'(sts.position);
							st_d      = ST_OK;
						end
					end
					ACT_SEARCH, ACT_DUMP: begin
						if (sts.empty) begin
							st_d = is_search ? ST_NOTFOUND : ST_EMPTY;
						end else begin
							cmd.rd_en = 1'b1;
							rd_addr   = '0;
							i_d       = '0;
							pend_d    = 1'b0;
							state_d   = S_SCAN;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			// walk down from the top, moving each entry one slot up
			S_SHUP: begin
				if (XW'(i_q) > XW'(sts.position)) begin
					cmd.rd_en = 1'b1;
					cmd.mv    = 1'b1;
					rd_addr   = i_q - AW'(1);
					wr_addr   = i_q;
					i_d       = i_q - AW'(1);
				end else begin
					state_d = S_INSW;
				end
			end
			S_INSW: begin
				cmd.wr_en   = 1'b1;
				cmd.cnt_inc = 1'b1;
				wr_addr     = AW'(sts.position);
				st_d        = ST_OK;
				state_d     = S_REPLY;
			end
			// walk up from the hole, moving each entry one slot down
			S_SHDN: begin
				if ((XW'(i_q) + XW'(1)) < XW'(count)) begin
					cmd.rd_en = 1'b1;
					cmd.mv    = 1'b1;
					rd_addr   = i_q + AW'(1);
					wr_addr   = i_q;
					i_d       = i_q + AW'(1);
				end else begin
					cmd.cnt_dec = 1'b1;
					st_d        = ST_OK;
					state_d     = S_REPLY;
				end
			end
			// read data holds entry i_q; a found result waits one match so last is known
			S_SCAN: begin
				if (!is_search) begin
					if (sts.out_free) begin
						cmd.out_load     = 1'b1;
						cmd.out_status   = ST_ELEMENT;
						cmd.out_use_data = 1'b1;
						cmd.out_last     = last_el;
						out_index        = i_q;
						if (last_el) begin
							state_d = S_IDLE;
						end else begin
							cmd.rd_en = 1'b1;
							rd_addr   = i_q + AW'(1);
							i_d       = i_q + AW'(1);
						end
					end
				end else if (!(sts.match && pend_q && !sts.out_free)) begin
					if (sts.match && pend_q) begin
						cmd.out_load   = 1'b1;
						cmd.out_status = ST_FOUND;
						out_index      = pend_idx_q;
					end
					if (sts.match) begin
						pend_d     = 1'b1;
						pend_idx_d = i_q;
					end
					if (last_el) begin
						state_d = S_SFIN;
					end else begin
						cmd.rd_en = 1'b1;
						rd_addr   = i_q + AW'(1);
						i_d       = i_q + AW'(1);
					end
				end
			end
			S_SFIN: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_last   = 1'b1;
					cmd.out_status = pend_q ? ST_FOUND : ST_NOTFOUND;
					out_index      = pend_q ? pend_idx_q : '0;
					pend_d         = 1'b0;
					state_d        = S_IDLE;
				end
			end
			S_REPLY: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_last   = 1'b1;
					cmd.out_status = st_q;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef SYNTH
	a_take_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> state_q == S_DECODE)
		else $error("accepted item not decoded");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && cmd.out_last) |=> state_q == S_IDLE)
		else $error("final result given while still busy");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !(cmd.rd_en || cmd.wr_en || cmd.mv || cmd.out_load))
		else $error("memory or result activity while idle");
`endif

endmodule

FILE: hw/rtl/ordered_array_list_engine.sv
// ordered_array_list_engine: top level; joins the controller and the datapath.
// Depends on oale_pkg, oale_ctrl and oale_dp.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+----------------------------------
//   req      | in        | req_valid/req_ready  | action, position, value
//   rsp      | out       | rsp_valid/rsp_ready  | status, index, data, length, last
//
// shifts, search and dump walk the entry memory one entry per cycle through its single
// read port; search and dump can stall while a held result waits for rsp_ready.
// one item is worked on at a time; req_ready is high only between items.
// reset clears the entry count and the control state; entries are not cleared.
// a held result does not stop the next item from being taken.

module ordered_array_list_engine #(
	parameter int DEPTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  oale_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output oale_pkg::rsp_t  rsp
);
	import oale_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	ctl_cmd_t      cmd;
	dp_sts_t       sts;
	logic [CW-1:0] count;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] out_index;

	oale_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.count     (count),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.out_index (out_index)
	);

	oale_dp #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.out_index (out_index),
		.sts       (sts),
		.count     (count),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

FILE: bench/list_checker.sv
// list_checker: watches both channels of ordered_array_list_engine, keeps its own copy
// of the list, predicts every result and compares it field by field.
// Depends on oale_pkg.

module list_checker #(
	parameter int DEPTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  oale_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  oale_pkg::rsp_t rsp,
	output int             fail_count,
	output int             pending_n,
	output int             held_n,
	output int             item_count,
	output int             result_count,
	output int             full_count,
	output int             peak_held
);
	import oale_pkg::*;

	logic signed [DATA_W-1:0] list_mem [DEPTH];
	int list_len = 0;
	int fails = 0;
	int items = 0;
	int results = 0;
	int fulls = 0;
	int peak = 0;
	rsp_t rsp_due [$];

	task automatic flag(input string msg);
		fails++;
		$display("mismatch at result %0d: %s", results, msg);
	endtask

	task automatic push_rsp(input logic [2:0] st, input int idx,
			input logic signed [DATA_W-1:0] word, input bit fin);
		rsp_due.push_back(rsp_t'{st, POS_W'(idx), word, POS_W'(list_len), fin});
	endtask

	// applies one command to the list copy and queues the results it causes
	task automatic run_command(input req_t c);
		int p;
		int i;
		int hits;
		int seen;
		p = c.position;
		hits = 0;
		seen = 0;
		case (c.action)
			ACT_INSERT: begin
				// full is checked before the position
				if (list_len >= DEPTH) begin
					push_rsp(ST_FULL, 0, '0, 1'b1);
					fulls++;
				end else if (p > list_len) begin
					push_rsp(ST_BADPOS, 0, '0, 1'b1);
				end else begin
					for (i = list_len; i > p; i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[p] = c.value;
					list_len++;
					push_rsp(ST_OK, 0, '0, 1'b1);
				end
			end
			ACT_DELETE: begin
				if (p >= list_len) begin
					push_rsp(ST_BADPOS, 0, '0, 1'b1);
				end else begin
					for (i = p; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i + 1];
					list_len--;
					push_rsp(ST_OK, 0, '0, 1'b1);
				end
			end
			ACT_UPDATE: begin
				if (p >= list_len) begin
					push_rsp(ST_BADPOS, 0, '0, 1'b1);
				end else begin
					list_mem[p] = c.value;
					push_rsp(ST_OK, 0, '0, 1'b1);
				end
			end
			ACT_SEARCH: begin
				for (i = 0; i < list_len; i++)
					if (list_mem[i] == c.value) hits++;
				if (hits == 0) begin
					push_rsp(ST_NOTFOUND, 0, '0, 1'b1);
				end else begin
					for (i = 0; i < list_len; i++) begin
						if (list_mem[i] == c.value) begin
							seen++;
							push_rsp(ST_FOUND, i, '0, seen == hits);
						end
					end
				end
			end
			ACT_DUMP: begin
				if (list_len == 0) begin
					push_rsp(ST_EMPTY, 0, '0, 1'b1);
				end else begin
					for (i = 0; i < list_len; i++)
						push_rsp(ST_ELEMENT, i, list_mem[i], i == list_len - 1);
				end
			end
			default: begin
				// codes above dump are dropped without a result
			end
		endcase
		if (list_len > peak) peak = list_len;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			list_len = 0;
			rsp_due.delete();
		end else begin
			// results first: a result taken on this edge cannot come from an item taken on it
			if (rsp_valid && rsp_ready) begin
				results++;
				if (rsp_due.size() == 0) begin
					flag($sformatf("item with nothing expected: status %0d index %0d data %0d",
						rsp.status, rsp.index, rsp.data));
				end else begin
					want = rsp_due.pop_front();
					if (rsp.status !== want.status)
						flag($sformatf("status %0d, expected %0d", rsp.status, want.status));
					if (rsp.index !== want.index)
						flag($sformatf("index %0d, expected %0d", rsp.index, want.index));
					if (rsp.data !== want.data)
						flag($sformatf("data %0d, expected %0d", rsp.data, want.data));
					if (rsp.length !== want.length)
						flag($sformatf("length %0d, expected %0d", rsp.length, want.length));
					if (rsp.last !== want.last)
						flag($sformatf("last %0b, expected %0b", rsp.last, want.last));
				end
			end
			if (req_valid && req_ready) begin
				items++;
				run_command(req);
			end
		end
		fail_count   <= fails;
		pending_n    <= rsp_due.size();
		held_n       <= list_len;
		item_count   <= items;
		result_count <= results;
		full_count   <= fulls;
		peak_held    <= peak;
	end

endmodule

FILE: bench/testbench.sv
// testbench: clock, reset, stimulus and verdict for ordered_array_list_engine.
// Depends on oale_pkg, the engine RTL and list_checker, which checks every result.

module testbench;
	import oale_pkg::*;

	localparam int DEPTH = 32;
	localparam int TAIL_CYCLES = 3 * DEPTH + 20;
	localparam int STALL_LIMIT = 4000;
	localparam logic [2:0] ACT_CODE_MAX = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	int fail_count;
	int pending_n;
	int held_n;
	int item_count;
	int result_count;
	int full_count;
	int peak_held;
	int stall_cycles = 0;
	bit idle_on = 1'b1;

	always #1 clk = ~clk;

	ordered_array_list_engine #(.DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	list_checker #(.DEPTH(DEPTH)) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp          (rsp),
		.fail_count   (fail_count),
		.pending_n    (pending_n),
		.held_n       (held_n),
		.item_count   (item_count),
		.result_count (result_count),
		.full_count   (full_count),
		.peak_held    (peak_held)
	);

	// cycles with no item moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// result side: random stretches of rsp_ready high and, while idle_on is set, stall bursts
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!idle_on || $urandom_range(2) != 0) begin
				rsp_ready <= 1'b1;
				repeat ($urandom_range(16, 1)) @(posedge clk);
			end else begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(12, 1)) @(posedge clk);
			end
		end
	end

	function automatic logic signed [DATA_W-1:0] rand_word();
		case ($urandom_range(7)) inside
			[0:3]: return DATA_W'($urandom_range(7));
			4: begin
				case ($urandom_range(3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return -32'sd1;
					default: return 32'sd0;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	// top is the highest in-range position, negative when there is none
	function automatic logic [POS_W-1:0] pick_pos(input int top);
		int r;
		r = $urandom_range(9);
		if (r == 0 || top < 0) return POS_W'($urandom());
		if (r == 1) return POS_W'(top + 1);
		return POS_W'($urandom_range(top));
	endfunction

	// held_n may lag by one item, which only nudges the position mix
	function automatic req_t make_cmd(input int ins_w, input int del_w);
		req_t c;
		int r;
		c.value = rand_word();
		r = $urandom_range(99);
		if (r < 3) begin
			c.action = 3'($urandom_range(ACT_CODE_MAX, ACT_DUMP + 1));
			c.position = POS_W'($urandom());
		end else if (r < 3 + ins_w) begin
			c.action = ACT_INSERT;
			c.position = pick_pos(held_n);
		end else if (r < 3 + ins_w + del_w) begin
			c.action = ACT_DELETE;
			c.position = pick_pos(held_n - 1);
		end else begin
			r = $urandom_range(9);
			c.position = POS_W'($urandom());
			if (r < 4) begin
				c.action = ACT_UPDATE;
				c.position = pick_pos(held_n - 1);
			end else if (r < 9) begin
				c.action = ACT_SEARCH;
			end else begin
				c.action = ACT_DUMP;
			end
		end
		return c;
	endfunction

	// drive one item and hold it until it is taken
	task automatic issue(input req_t c);
		if (idle_on && $urandom_range(5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(12, 1)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= c;
		do @(posedge clk); while (!req_ready);
	endtask

	// hold off the sender until every expected result is back
	task automatic drain_wait();
		req_valid <= 1'b0;
		@(posedge clk);
		wait (pending_n == 0);
		@(posedge clk);
	endtask

	initial begin
		int n;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corner cases
		issue(req_t'{ACT_DUMP, 6'd0, 32'sd0});
		issue(req_t'{ACT_SEARCH, 6'd0, 32'sd0});
		issue(req_t'{ACT_DELETE, 6'd0, 32'sd0});
		issue(req_t'{ACT_UPDATE, 6'd0, 32'sd9});
		issue(req_t'{ACT_INSERT, 6'd1, 32'sd9});
		// build [5, min, 5, max] through front, end and middle inserts
		issue(req_t'{ACT_INSERT, 6'd0, 32'sh8000_0000});
		issue(req_t'{ACT_INSERT, 6'd1, 32'sh7fff_ffff});
		issue(req_t'{ACT_INSERT, 6'd1, 32'sd5});
		issue(req_t'{ACT_INSERT, 6'd0, 32'sd5});
		issue(req_t'{ACT_INSERT, 6'd63, 32'sd1});
		issue(req_t'{ACT_SEARCH, 6'd0, 32'sd5});
		issue(req_t'{ACT_SEARCH, 6'd63, 32'sd0});
		issue(req_t'{ACT_UPDATE, 6'd2, -32'sd1});
		issue(req_t'{ACT_UPDATE, 6'd4, 32'sd3});
		issue(req_t'{ACT_DUMP, 6'd0, 32'sd0});
		// unused action codes
		issue(req_t'{3'(ACT_DUMP + 1), 6'd63, 32'sh5555_aaaa});
		issue(req_t'{3'(ACT_DUMP + 2), 6'd0, 32'shffff_ffff});
		issue(req_t'{ACT_CODE_MAX, 6'd21, 32'sh0f0f_f0f0});
		issue(req_t'{ACT_DELETE, 6'd4, 32'sd0});
		issue(req_t'{ACT_DELETE, 6'd3, 32'sd0});
		issue(req_t'{ACT_DELETE, 6'd0, 32'sd0});
		issue(req_t'{ACT_DELETE, 6'd32, 32'sd0});
		issue(req_t'{ACT_SEARCH, 6'd0, -32'sd1});
		issue(req_t'{ACT_DUMP, 6'd0, 32'sd0});
		issue(req_t'{ACT_INSERT, 6'd2, 32'sh5555_aaaa});
		drain_wait();

		// each round fills the list toward capacity, mixes, then drains it, each phase capped at 60 commands
		for (int round = 0; round < 3; round++) begin
			idle_on = (round < 2);
			for (n = 0; n < 60 && held_n < DEPTH; n++)
				issue(make_cmd(80, 5));
			drain_wait();
			repeat (2) issue(req_t'{ACT_INSERT, POS_W'($urandom()), rand_word()});
			repeat (10) issue(make_cmd(25, 25));
			for (n = 0; n < 60 && held_n > 0; n++)
				issue(make_cmd(5, 80));
			drain_wait();
		end

		wait (pending_n == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("run covered %0d commands and %0d results", item_count, result_count);
		$display("list was full on %0d inserts, held up to %0d entries", full_count,
			peak_held);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/oale_pkg.sv
hw/rtl/oale_dp.sv
hw/rtl/oale_ctrl.sv
hw/rtl/ordered_array_list_engine.sv
bench/list_checker.sv
bench/testbench.sv
